/* design/bpks_pkg.sv */
// Package for the button pairing key set.
// Types, codes and constants shared by the chain, the cells, the top level and the checker.
// No dependencies.
`default_nettype none
package bpks_pkg;

	localparam int unsigned MAX_KEYS_DEF = 8;
	localparam logic [7:0]  NO_KEY = 8'hFF;
	localparam logic [31:0] LONG_PRESS_RESET = 32'd10000;

	// register index, taken from paddr[2]
	localparam logic REG_LONG_PRESS = 1'b0;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic        switch_pressed;
		logic [7:0]  key;
		logic [31:0] now_ms;
		logic [2:0]  read_index;
	} poll_t;

	typedef struct packed {
		logic       added;
		logic       cleared;
		logic [3:0] member_count;
		logic       set_full;
		logic       key_is_member;
		logic [7:0] member_at_index;
	} result_t;

	// control broadcast into the cell row
	typedef struct packed {
		logic       wr_en;
		logic [7:0] key;
		logic [2:0] rd_idx;
	} chain_ctl_t;

	// what falls out of the far end of the row
	typedef struct packed {
		logic       hit;
		logic [7:0] rd_data;
	} chain_stat_t;

endpackage
`default_nettype wire

/* design/bpks_cell.sv */
// One slot of the key set: holds a key byte, compares it and passes hit and read data on.
// Depends on bpks_pkg.
`default_nettype none
module bpks_cell
	import bpks_pkg::*;
#(
	parameter int unsigned MAX_KEYS = MAX_KEYS_DEF,
	parameter int unsigned IDX = 0,
	localparam int unsigned CW = $clog2(MAX_KEYS + 1)
) (
	input  wire logic          clk,
	input  wire logic [CW-1:0] count,
	input  wire chain_ctl_t    ctl,
	input  wire logic          hit_in,
	input  wire logic [7:0]    rd_in,
	output logic               hit_out,
	output logic [7:0]         rd_out
);

	localparam bit REACH = (IDX < 8);

	logic [7:0] key_q;
	logic       occ;
	logic       rd_sel;

	assign occ = (CW'(IDX) < count);
	assign rd_sel = REACH && occ && (ctl.rd_idx == 3'(IDX));

	// slot is written only when it is the next free one
	always_ff @(posedge clk) begin
		if (ctl.wr_en && (count == CW'(IDX))) begin
			key_q <= ctl.key;
		end
	end

	assign hit_out = hit_in | (occ && (key_q == ctl.key));
	assign rd_out = rd_sel ? key_q : rd_in;

endmodule
`default_nettype wire

/* design/bpks_chain.sv */
// Row of key cells; hit and read data ripple from cell 0 to the last cell.
// Depends on bpks_pkg and bpks_cell.
`default_nettype none
module bpks_chain
	import bpks_pkg::*;
#(
	parameter int unsigned MAX_KEYS = MAX_KEYS_DEF,
	localparam int unsigned CW = $clog2(MAX_KEYS + 1)
) (
	input  wire logic          clk,
	input  wire logic [CW-1:0] count,
	input  wire chain_ctl_t    ctl,
	output chain_stat_t        stat
);

	logic       hit_w [MAX_KEYS+1];
	logic [7:0] rd_w  [MAX_KEYS+1];

	assign hit_w[0] = 1'b0;
	assign rd_w[0] = 8'h00;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		bpks_cell #(
			.MAX_KEYS(MAX_KEYS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.count(count),
			.ctl(ctl),
			.hit_in(hit_w[i]),
			.rd_in(rd_w[i]),
			.hit_out(hit_w[i+1]),
			.rd_out(rd_w[i+1])
		);
	end

	assign stat.hit = hit_w[MAX_KEYS];
	assign stat.rd_data = rd_w[MAX_KEYS];

endmodule
`default_nettype wire

/* design/button_pairing_key_set.sv */
// Button pairing key set.
//
// Poll channel (poll_valid/poll_ready, payload poll): one transfer per switch
// poll carrying the switch level, a candidate key, a ms timestamp and a read index.
// Result channel (result_valid/result_ready, payload result): one transfer per poll.
// APB port: register 0 at byte address 0 is long_press_ms (reset 10000).
//
// Timing: a poll is registered at its transfer and evaluated against the cell row
// in the S_EVAL state that follows; its result is loaded into the output register
// at the end of an S_EVAL cycle in which that register is free or being taken,
// which sets result_valid. The poll channel is ready again in the cycle after the
// result loads, so a new poll is taken only once the previous result has loaded.
// A result waiting in the output register does not block the next poll transfer;
// evaluation of that poll waits until the register is free or being taken.
// Reset empties the set, marks the switch released, zeroes the press start and
// restores long_press_ms. No clearing pass is needed.
// Depends on bpks_pkg and bpks_chain.
`default_nettype none
module button_pairing_key_set
	import bpks_pkg::*;
#(
	parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        poll_valid,
	output logic             poll_ready,
	input  wire poll_t       poll,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned CW = $clog2(MAX_KEYS + 1);
	localparam int unsigned XW = (CW > 3) ? CW : 3;

	state_t state_q, state_d;

	poll_t       item_q;
	result_t     res_q;
	logic        res_valid_q;
	logic [CW-1:0] count_q;
	logic        was_q;
	logic [31:0] start_q;
	logic [31:0] lp_q;

	logic        load;
	logic [31:0] elapsed;
	logic        long_hit;
	logic        pressed;
	logic        do_clear;
	logic        do_add;
	logic        do_start;
	logic [CW-1:0] new_count;
	logic [7:0]  at;
	result_t     res_d;

	chain_ctl_t  ctl;
	chain_stat_t stat;

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LONG_PRESS) ? lp_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= LONG_PRESS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_LONG_PRESS)) begin
			lp_q <= pwdata;
		end
	end

	// control FSM
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (poll_valid) state_d = S_EVAL;
			S_EVAL: if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		poll_ready = 1'b0;
		load = 1'b0;
		unique case (state_q)
			S_IDLE: poll_ready = 1'b1;
			S_EVAL: load = !res_valid_q || result_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			item_q <= poll;
		end
	end

	// poll decision
	assign pressed = item_q.switch_pressed;
	assign elapsed = item_q.now_ms - start_q;
	assign long_hit = was_q && (elapsed > lp_q);
	assign do_clear = pressed && long_hit;
	assign do_add = pressed && !long_hit && (item_q.key != NO_KEY) && !stat.hit
		&& (count_q < CW'(MAX_KEYS));
	assign do_start = pressed && !long_hit && !do_add && !was_q;

	assign ctl.wr_en = load && do_add;
	assign ctl.key = item_q.key;
	assign ctl.rd_idx = item_q.read_index;

	bpks_chain #(
		.MAX_KEYS(MAX_KEYS)
	) u_chain (
		.clk(clk),
		.count(count_q),
		.ctl(ctl),
		.stat(stat)
	);

	always_comb begin
		if (do_clear) begin
			new_count = '0;
		end else if (do_add) begin
			new_count = count_q + CW'(1);
		end else begin
			new_count = count_q;
		end
	end

	// read data after the update: a fresh key lands at the old count
	always_comb begin
		if (do_clear) begin
			at = 8'h00;
		end else if (do_add && (XW'(item_q.read_index) == XW'(count_q))) begin
			at = item_q.key;
		end else begin
			at = stat.rd_data;
		end
	end

	always_comb begin
		res_d.added = do_add;
		res_d.cleared = do_clear;
		res_d.member_count = 4'(new_count);
		res_d.set_full = (new_count == CW'(MAX_KEYS));
		res_d.key_is_member = (item_q.key != NO_KEY) && !do_clear && (do_add || stat.hit);
		res_d.member_at_index = at;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			was_q <= 1'b0;
			start_q <= 32'h0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				count_q <= new_count;
				was_q <= pressed;
				if (do_start) begin
					start_q <= item_q.now_ms;
				end
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule
`default_nettype wire

/* design/bpks_checker.sv */
// Port-level checks for the button pairing key set, bound to the top level.
// Depends on bpks_pkg and button_pairing_key_set.
`default_nettype none
module bpks_checker
	import bpks_pkg::*;
#(
	parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    poll_valid,
	input wire logic    poll_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one poll at a time: no transfer in the cycle after a transfer
	a_poll_gap: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> !poll_ready)
		else $error("poll taken in back-to-back cycles");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.cleared |-> !result.added && (result.member_count == 4'd0)
			&& !result.key_is_member)
		else $error("cleared result with keys left");

	a_added_member: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.added |-> result.key_is_member && (result.member_count != 4'd0))
		else $error("added key not reported as member");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (MAX_KEYS > 15)
			|| (result.set_full == (result.member_count == 4'(MAX_KEYS))))
		else $error("set_full disagrees with member_count");

endmodule

bind button_pairing_key_set bpks_checker #(
	.MAX_KEYS(MAX_KEYS)
) u_bpks_checker (
	.clk(clk),
	.arst_n(arst_n),
	.poll_valid(poll_valid),
	.poll_ready(poll_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for button_pairing_key_set: poll/result valid-ready channels, APB setup.
// Predicts every result from its own copy of the key set and compares field by field.
// Depends on bpks_pkg and the button_pairing_key_set RTL.
`default_nettype none
module testbench;
	import bpks_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LIMIT = 200000;
	localparam int          HOLD_AT = 300;
	localparam int          HOLD_CYCLES = 300;
	localparam int          ITEMS_PER_PHASE = 213;
	localparam logic [2:0]  LONG_PRESS_ADDR = {REG_LONG_PRESS, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        poll_valid = 1'b0;
	logic        poll_ready;
	poll_t       poll = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	button_pairing_key_set u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_ready   (poll_ready),
		.poll         (poll),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted key set state
	logic [7:0]  ks_keys [MAX_KEYS_DEF];
	logic [3:0]  ks_count = '0;
	logic        ks_was_pressed = 1'b0;
	logic [31:0] ks_press_start = '0;
	logic [31:0] ks_long_press = LONG_PRESS_RESET;

	poll_t       poll_q [$];
	result_t     expected_results [$];
	int          fail_cnt = 0;
	int          results_seen = 0;
	int          cycles = 0;
	logic        poll_xfer = 1'b0;
	logic [31:0] stim_now = '0;
	logic [7:0]  key_pool [12];

	function automatic logic holds_key(input logic [7:0] k);
		logic found;
		found = 1'b0;
		if (k != NO_KEY)
			for (int i = 0; i < MAX_KEYS_DEF; i++)
				if (i < ks_count && ks_keys[i] == k)
					found = 1'b1;
		return found;
	endfunction

	function automatic result_t eval_poll(input poll_t p);
		result_t     r;
		logic [31:0] elapsed;
		r = '0;
		if (p.switch_pressed) begin
			elapsed = p.now_ms - ks_press_start;
			if (ks_was_pressed && elapsed > ks_long_press) begin
				ks_count = '0;
				r.cleared = 1'b1;
			end else if (p.key != NO_KEY && !holds_key(p.key) && ks_count < MAX_KEYS_DEF) begin
				ks_keys[ks_count[2:0]] = p.key;
				ks_count = ks_count + 1'b1;
				r.added = 1'b1;
			end else if (!ks_was_pressed) begin
				ks_press_start = p.now_ms;
			end
		end
		ks_was_pressed = p.switch_pressed;
		r.member_count = ks_count;
		r.set_full = (ks_count == MAX_KEYS_DEF);
		r.key_is_member = holds_key(p.key);
		r.member_at_index = (p.read_index < ks_count) ? ks_keys[p.read_index] : 8'h00;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// monitor: prediction at each poll transfer, check at each result transfer
	always @(posedge clk) begin
		result_t want;
		poll_xfer <= poll_valid && poll_ready;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("%0t: timeout", $time);
				$display("== FAIL ==");
				$finish;
			end else begin
				if (psel && penable && pwrite && pready && paddr == LONG_PRESS_ADDR)
					ks_long_press = pwdata;
				if (poll_valid && poll_ready)
					expected_results.push_back(eval_poll(poll));
				if (result_valid && result_ready) begin
					results_seen++;
					if (expected_results.size() == 0) begin
						fail_cnt++;
						$display("%0t: unexpected result, expected none, actual %0h",
							$time, result);
					end else begin
						want = expected_results.pop_front();
						check_field("added", 32'(want.added), 32'(result.added));
						check_field("cleared", 32'(want.cleared), 32'(result.cleared));
						check_field("member_count", 32'(want.member_count),
							32'(result.member_count));
						check_field("set_full", 32'(want.set_full), 32'(result.set_full));
						check_field("key_is_member", 32'(want.key_is_member),
							32'(result.key_is_member));
						check_field("member_at_index", 32'(want.member_at_index),
							32'(result.member_at_index));
					end
				end
			end
		end
	end

	// poll driver: bursts of transfers with random gaps in between
	int gap_left = 0;
	int burst_left = 1;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!poll_valid || poll_xfer) begin
				if (gap_left > 0) begin
					gap_left--;
					poll_valid <= 1'b0;
				end else if (poll_q.size() > 0) begin
					poll <= poll_q.pop_front();
					poll_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					poll_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: own stall pattern plus one long hold-off
	int rx_mode = 0;
	int rx_cnt = 0;
	int rx_len = 40;
	int hold_left = 0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				rx_cnt++;
				if (rx_cnt >= rx_len) begin
					rx_cnt = 0;
					rx_len = $urandom_range(10, 80);
					rx_mode = $urandom_range(0, 2);
				end
				case (rx_mode)
					0: result_ready <= 1'b1;
					1: result_ready <= (rx_cnt % 3) != 0;
					default: result_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	task automatic queue_poll(input logic pressed, input logic [7:0] k,
			input logic [31:0] now, input logic [2:0] idx);
		poll_t p;
		p.switch_pressed = pressed;
		p.key = k;
		p.now_ms = now;
		p.read_index = idx;
		poll_q.push_back(p);
	endtask

	task automatic wait_drained();
		while (poll_q.size() != 0 || poll_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_long_press(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LONG_PRESS_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			fail_cnt++;
			$display("%0t: long_press_ms readback mismatch, expected %0h, actual %0h",
				$time, value, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] time_step(input logic [31:0] span);
		return ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, span);
	endfunction

	function automatic logic [7:0] pool_key();
		return ($urandom_range(0, 7) == 0) ? NO_KEY : key_pool[$urandom_range(0, 11)];
	endfunction

	// mostly release-then-hold sessions drawing keys from a small pool, some raw noise
	task automatic queue_random(input logic [31:0] lp, input int n);
		int          made;
		logic [31:0] span;
		made = 0;
		span = (lp > 32'd100000) ? lp / 3 : lp * 2 + 32'd3;
		for (int i = 0; i < 12; i++)
			key_pool[i] = 8'($urandom());
		while (made < n) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_poll(1'($urandom_range(0, 1)), 8'($urandom()), $urandom(),
					3'($urandom()));
				made++;
			end else begin
				repeat ($urandom_range(1, 2)) begin
					stim_now = stim_now + time_step(span);
					queue_poll(1'b0, pool_key(), stim_now, 3'($urandom()));
					made++;
				end
				repeat ($urandom_range(1, 12)) begin
					stim_now = stim_now + time_step(span);
					queue_poll(1'b1, pool_key(), stim_now, 3'($urandom()));
					made++;
				end
			end
		end
	endtask

	initial begin
		logic [31:0] lp_set [6];
		lp_set[0] = 32'd1;
		lp_set[1] = 32'hFFFF_FFFF;
		lp_set[2] = 32'd37;
		lp_set[3] = 32'd500000;
		lp_set[4] = 32'd10000;
		lp_set[5] = $urandom_range(1, 1 << 20);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pass at the reset hold time
		queue_poll(1'b0, 8'hFF, 32'd0, 3'd0);
		queue_poll(1'b1, 8'hFF, 32'd100, 3'd1);         // press edge, start recorded
		queue_poll(1'b1, 8'h00, 32'd200, 3'd0);
		queue_poll(1'b1, 8'h00, 32'd300, 3'd7);         // already a member
		queue_poll(1'b1, 8'h80, 32'd400, 3'd1);
		queue_poll(1'b1, 8'h01, 32'd500, 3'd2);
		queue_poll(1'b1, 8'h7F, 32'd600, 3'd3);
		queue_poll(1'b1, 8'hFE, 32'd700, 3'd4);
		queue_poll(1'b1, 8'h55, 32'd800, 3'd5);
		queue_poll(1'b1, 8'hAA, 32'd900, 3'd6);
		queue_poll(1'b1, 8'h33, 32'd1000, 3'd7);        // set now full
		queue_poll(1'b1, 8'h44, 32'd1100, 3'd7);        // full, key dropped
		queue_poll(1'b0, 8'h44, 32'd1200, 3'd3);
		queue_poll(1'b1, 8'h44, 32'd5000, 3'd2);        // full on press edge, start recorded
		queue_poll(1'b1, 8'hFF, 32'd15000, 3'd0);       // elapsed equals hold time
		queue_poll(1'b1, 8'h12, 32'd15001, 3'd0);       // long press clears
		queue_poll(1'b1, 8'h12, 32'd15002, 3'd1);       // still held, clears again
		queue_poll(1'b0, 8'hFF, 32'd16000, 3'd0);
		queue_poll(1'b1, 8'h12, 32'hFFFF_FFF0, 3'd0);   // add on edge keeps old start
		queue_poll(1'b1, 8'hFF, 32'hFFFF_FFF8, 3'd0);
		queue_poll(1'b0, 8'h00, 32'hFFFF_FFF9, 3'd5);
		queue_poll(1'b1, 8'hFF, 32'hFFFF_FFFA, 3'd6);
		queue_poll(1'b1, 8'h12, 32'h0000_0010, 3'd0);   // timestamp wrapped, no clear
		queue_poll(1'b0, 8'h12, 32'h0000_0020, 3'd0);

		foreach (lp_set[i]) begin
			wait_drained();
			program_long_press(lp_set[i]);
			queue_random(lp_set[i], ITEMS_PER_PHASE);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
